>>> hdl/clsr_pkg.sv
// ----------------------------------------------------------------------------
// clsr_pkg
// Shared constants and types of the combined LCG / shuffle-table generator.
// ----------------------------------------------------------------------------
package clsr_pkg;

   localparam int GEN_W  = 31;  // generator state and sample width
   localparam int MUL_W  = 16;  // multiplier constant width
   localparam int FOLD_W = 8;   // 2^31 - modulus fits here
   localparam int FRAC_W = 32;

   localparam int DEFAULT_TABLE_SIZE   = 32;
   localparam int DEFAULT_WARMUP_EXTRA = 8;

   localparam logic [GEN_W-1:0]  MOD_ONE     = 31'd2147483563;
   localparam logic [GEN_W-1:0]  MOD_TWO     = 31'd2147483399;
   localparam logic [MUL_W-1:0]  MUL_ONE     = 16'd40014;
   localparam logic [MUL_W-1:0]  MUL_TWO     = 16'd40692;
   // 2^31 mod modulus, used to fold the high part of a product back down
   localparam logic [FOLD_W-1:0] FOLD_ONE    = 8'd85;
   localparam logic [FOLD_W-1:0] FOLD_TWO    = 8'd249;
   localparam logic [GEN_W-1:0]  SECOND_SEED = 31'd123456789;
   // x * 2^32 / MOD_ONE = 2x + 170x / MOD_ONE
   localparam logic [FOLD_W-1:0] FRAC_MUL    = 8'd170;
   localparam logic [FRAC_W-1:0] FRAC_MAX    = 32'd4294966780;

   localparam logic OP_NEXT   = 1'b0;
   localparam logic OP_RESEED = 1'b1;

   typedef struct packed {
      logic start;
      logic sel_two;
   } mm_req_type;

   typedef struct packed {
      logic done;
      logic sel_two;
   } mm_rsp_type;

endpackage

>>> hdl/clsr_modmul.sv
// ----------------------------------------------------------------------------
// clsr_modmul
// Three-stage modular multiplier shared by both generators: product,
// fold of the high part by 2^31 mod m, final conditional correction.
// ----------------------------------------------------------------------------
module clsr_modmul (
   input  logic                          clock,
   input  logic                          reset,
   input  clsr_pkg::mm_req_type          req,
   input  logic [clsr_pkg::GEN_W-1:0]    operand,
   output clsr_pkg::mm_rsp_type          rsp,
   output logic [clsr_pkg::GEN_W-1:0]    result
);

   localparam int GenW  = clsr_pkg::GEN_W;
   localparam int ProdW = clsr_pkg::GEN_W + clsr_pkg::MUL_W;
   localparam int FoldW = clsr_pkg::GEN_W + 1;

   logic                        v0_ff, v0_in, v1_ff, v1_in, v2_ff, v2_in;
   logic                        sel0_ff, sel0_in, sel1_ff, sel1_in, sel2_ff, sel2_in;
   logic [ProdW-1:0]            prod_ff, prod_in;
   logic [FoldW-1:0]            fold_ff, fold_in;
   logic [GenW-1:0]             res_ff, res_in;
   logic [clsr_pkg::MUL_W-1:0]  mult;
   logic [clsr_pkg::FOLD_W-1:0] fold_c0, fold_c1;
   logic [GenW-1:0]             modv, low;

   always_comb begin
      mult    = req.sel_two ? clsr_pkg::MUL_TWO : clsr_pkg::MUL_ONE;
      v0_in   = req.start;
      sel0_in = req.sel_two;
      prod_in = ProdW'(operand) * ProdW'(mult);

      fold_c0 = sel0_ff ? clsr_pkg::FOLD_TWO : clsr_pkg::FOLD_ONE;
      v1_in   = v0_ff;
      sel1_in = sel0_ff;
      fold_in = FoldW'(prod_ff[ProdW-1:GenW]) * FoldW'(fold_c0)
              + FoldW'(prod_ff[GenW-1:0]);

      // fold < 2^31 + 2^24: either small with bit 31 set, or below 2m
      fold_c1 = sel1_ff ? clsr_pkg::FOLD_TWO : clsr_pkg::FOLD_ONE;
      modv    = sel1_ff ? clsr_pkg::MOD_TWO : clsr_pkg::MOD_ONE;
      low     = fold_ff[GenW-1:0];
      v2_in   = v1_ff;
      sel2_in = sel1_ff;
      if (fold_ff[GenW]) begin
         res_in = low + GenW'(fold_c1);
      end else if (low >= modv) begin
         res_in = low - modv;
      end else begin
         res_in = low;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      sel0_ff <= sel0_in;
      sel1_ff <= sel1_in;
      sel2_ff <= sel2_in;
      prod_ff <= prod_in;
      fold_ff <= fold_in;
      res_ff  <= res_in;
   end

   assign rsp.done    = v2_ff;
   assign rsp.sel_two = sel2_ff;
   assign result      = res_ff;

endmodule

>>> hdl/combined_lcg_shuffle_rng.sv
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng
// Combined two-stream LCG with a shuffle table. A word with tuser = 1
// reseeds: stream one from tdata (values below 1 load 1), stream two with
// 123456789, then TABLE_SIZE + WARMUP_EXTRA steps of stream one fill the
// table; no result word. A word with tuser = 0 steps both streams, mixes
// through the table and returns sample and its Q0.32 fraction; if the
// generator was never seeded it first reseeds with 1. Both streams share
// one three-stage modular multiplier. A next word runs two passes through
// the multiplier, a reciprocal-multiply slot estimate with a one-step
// correction, the table read-modify-write and three fraction steps; an
// unseeded next first runs a full reseed. The block takes one word at a
// time; a finished result waits in the output register while the next
// word is accepted.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng #(
   parameter int TABLE_SIZE   = clsr_pkg::DEFAULT_TABLE_SIZE,
   parameter int WARMUP_EXTRA = clsr_pkg::DEFAULT_WARMUP_EXTRA
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] seed
   input  logic [0:0]  req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [30:0] sample, [62:31] fraction, [63] zero
);

   localparam int GenW  = clsr_pkg::GEN_W;
   localparam int FracW = clsr_pkg::FRAC_W;
   localparam int IdxW  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int CntW  = $clog2(TABLE_SIZE + WARMUP_EXTRA + 1);
   localparam int QuoW  = $clog2(TABLE_SIZE + 1);
   localparam int CandW = QuoW + 1;
   localparam int QprW  = GenW + QuoW;
   localparam int ChkW  = GenW + CandW;
   localparam int TW    = GenW + clsr_pkg::FOLD_W;
   localparam logic [GenW-1:0] SlotDiv =
      GenW'(1 + (64'(clsr_pkg::MOD_ONE) - 64'd2) / TABLE_SIZE);
   localparam logic [QuoW-1:0] SlotRecip =
      QuoW'((64'd1 << GenW) / 64'(SlotDiv));

   typedef enum logic [12:0] {
      ST_IDLE       = 13'b0000000000001,
      ST_SEED_ISSUE = 13'b0000000000010,
      ST_SEED_WAIT  = 13'b0000000000100,
      ST_ONE_ISSUE  = 13'b0000000001000,
      ST_TWO_ISSUE  = 13'b0000000010000,
      ST_MUL_WAIT   = 13'b0000000100000,
      ST_DIV        = 13'b0000001000000,
      ST_READ       = 13'b0000010000000,
      ST_MIX        = 13'b0000100000000,
      ST_FRAC_MUL   = 13'b0001000000000,
      ST_FRAC_FOLD  = 13'b0010000000000,
      ST_FRAC_SUM   = 13'b0100000000000,
      ST_OUT        = 13'b1000000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [GenW-1:0]      gen_one_ff, gen_one_in, gen_two_ff, gen_two_in;
   logic [GenW-1:0]      last_ff, last_in;
   logic                 pend_ff, pend_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;

   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic [QuoW-1:0]      quo_ff, quo_in;
   logic [IdxW-1:0]      slot_ff, slot_in;
   logic [GenW-1:0]      rd_data_ff;
   logic [TW-1:0]        t_ff, t_in;
   logic [FracW:0]       fsum_ff, fsum_in;
   logic                 carry_ff, carry_in;
   logic [FracW-1:0]     frac_ff, frac_in;
   logic [GenW-1:0]      rsp_sample_ff, rsp_sample_in;
   logic [FracW-1:0]     rsp_frac_ff, rsp_frac_in;

   logic [GenW-1:0]      shuf_mem [TABLE_SIZE];
   logic                 wr_en;
   logic [IdxW-1:0]      wr_idx;
   logic [GenW-1:0]      wr_data;

   clsr_pkg::mm_req_type mm_req;
   clsr_pkg::mm_rsp_type mm_rsp;
   logic [GenW-1:0]      mm_operand, mm_result;

   logic                 accept, out_load;
   logic [QprW-1:0]      quo_prod;
   logic [CandW-1:0]     quo_cand, quo_fix, quo_sat;
   logic [ChkW-1:0]      cand_lim;
   logic [GenW+1:0]      diff;
   logic [clsr_pkg::FOLD_W-1:0] frac_hi;
   logic [GenW+1:0]      frac_low_sum;
   logic [FracW:0]       frac_full;

   clsr_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .req     (mm_req),
      .operand (mm_operand),
      .rsp     (mm_rsp),
      .result  (mm_result)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_load   = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      gen_one_in    = gen_one_ff;
      gen_two_in    = gen_two_ff;
      last_in       = last_ff;
      pend_in       = pend_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      cnt_in        = cnt_ff;
      quo_in        = quo_ff;
      slot_in       = slot_ff;
      t_in          = t_ff;
      fsum_in       = fsum_ff;
      carry_in      = carry_ff;
      frac_in       = frac_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_frac_in   = rsp_frac_ff;
      mm_req.start   = 1'b0;
      mm_req.sel_two = 1'b0;
      mm_operand     = gen_one_ff;
      wr_en          = 1'b0;
      wr_idx         = slot_ff;
      wr_data        = gen_one_ff;

      // slot estimate by reciprocal multiply, low by at most one
      quo_prod = QprW'(last_ff) * QprW'(SlotRecip);
      quo_cand = CandW'(quo_ff) + CandW'(1);
      cand_lim = ChkW'(quo_cand) * ChkW'(SlotDiv);
      quo_fix  = (ChkW'(last_ff) >= cand_lim) ? quo_cand : CandW'(quo_ff);
      quo_sat  = (quo_fix > CandW'(TABLE_SIZE - 1)) ? CandW'(TABLE_SIZE - 1) : quo_fix;

      diff         = (GenW + 2)'(rd_data_ff) - (GenW + 2)'(gen_two_ff);
      frac_hi      = t_ff[TW-1:GenW];
      frac_low_sum = (GenW + 2)'(t_ff[GenW-1:0])
                   + (GenW + 2)'(frac_hi) * (GenW + 2)'(clsr_pkg::FOLD_ONE);
      frac_full    = fsum_ff + (FracW + 1)'(carry_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               gen_two_in = clsr_pkg::SECOND_SEED;
               cnt_in     = CntW'(TABLE_SIZE + WARMUP_EXTRA - 1);
               if (req_tuser[0] == clsr_pkg::OP_RESEED) begin
                  pend_in    = 1'b0;
                  gen_one_in = (req_tdata[31] || req_tdata == 32'd0) ?
                               GenW'(1) : req_tdata[GenW-1:0];
                  state_in   = ST_SEED_ISSUE;
               end else if (last_ff == '0) begin
                  // never seeded, or seeded into the zero cycle
                  pend_in    = 1'b1;
                  gen_one_in = GenW'(1);
                  state_in   = ST_SEED_ISSUE;
               end else begin
                  gen_two_in = gen_two_ff;
                  state_in   = ST_ONE_ISSUE;
               end
            end
         end
         ST_SEED_ISSUE: begin
            mm_req.start = 1'b1;
            state_in     = ST_SEED_WAIT;
         end
         ST_SEED_WAIT: begin
            if (mm_rsp.done) begin
               gen_one_in = mm_result;
               if (cnt_ff < CntW'(TABLE_SIZE)) begin
                  wr_en   = 1'b1;
                  wr_idx  = cnt_ff[IdxW-1:0];
                  wr_data = mm_result;
               end
               if (cnt_ff == '0) begin
                  last_in  = mm_result;
                  state_in = pend_ff ? ST_ONE_ISSUE : ST_IDLE;
               end else begin
                  cnt_in   = cnt_ff - CntW'(1);
                  state_in = ST_SEED_ISSUE;
               end
            end
         end
         ST_ONE_ISSUE: begin
            mm_req.start = 1'b1;
            state_in     = ST_TWO_ISSUE;
         end
         ST_TWO_ISSUE: begin
            mm_req.start   = 1'b1;
            mm_req.sel_two = 1'b1;
            mm_operand     = gen_two_ff;
            quo_in         = quo_prod[QprW-1:GenW];
            state_in       = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (mm_rsp.done) begin
               if (mm_rsp.sel_two) begin
                  gen_two_in = mm_result;
                  state_in   = ST_DIV;
               end else begin
                  gen_one_in = mm_result;
               end
            end
         end
         ST_DIV: begin
            slot_in  = quo_sat[IdxW-1:0];
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_MIX;
         end
         ST_MIX: begin
            wr_en   = 1'b1;
            wr_idx  = slot_ff;
            wr_data = gen_one_ff;
            // wrap results below one into the top of the range
            if (diff[GenW+1] || diff == '0) begin
               last_in = GenW'(diff + (GenW + 2)'(clsr_pkg::MOD_ONE) - (GenW + 2)'(1));
            end else begin
               last_in = diff[GenW-1:0];
            end
            state_in = ST_FRAC_MUL;
         end
         ST_FRAC_MUL: begin
            t_in     = TW'(last_ff) * TW'(clsr_pkg::FRAC_MUL);
            state_in = ST_FRAC_FOLD;
         end
         ST_FRAC_FOLD: begin
            fsum_in  = (FracW + 1)'({last_ff, 1'b0}) + (FracW + 1)'(frac_hi);
            carry_in = frac_low_sum >= (GenW + 2)'(clsr_pkg::MOD_ONE);
            state_in = ST_FRAC_SUM;
         end
         ST_FRAC_SUM: begin
            frac_in  = (frac_full > (FracW + 1)'(clsr_pkg::FRAC_MAX)) ?
                       clsr_pkg::FRAC_MAX : frac_full[FracW-1:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_tvalid_in = 1'b1;
               rsp_sample_in = last_ff;
               rsp_frac_in   = frac_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         gen_one_ff    <= GenW'(1);
         gen_two_ff    <= clsr_pkg::SECOND_SEED;
         last_ff       <= '0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         gen_one_ff    <= gen_one_in;
         gen_two_ff    <= gen_two_in;
         last_ff       <= last_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      quo_ff        <= quo_in;
      slot_ff       <= slot_in;
      t_ff          <= t_in;
      fsum_ff       <= fsum_in;
      carry_ff      <= carry_in;
      frac_ff       <= frac_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_frac_ff   <= rsp_frac_in;
   end

   // shuffle table: one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         shuf_mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= shuf_mem[slot_ff];
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_frac_ff, rsp_sample_ff};

`ifndef SYNTHESIS
   a_mm_done_expected: assert property (@(posedge clock) disable iff (reset)
      mm_rsp.done |-> (state_ff == ST_SEED_WAIT || state_ff == ST_MUL_WAIT))
      else $error("multiplier result arrived outside a wait state");

   a_mm_reduced: assert property (@(posedge clock) disable iff (reset)
      mm_rsp.done |-> (mm_result < (mm_rsp.sel_two ? clsr_pkg::MOD_TWO
                                                   : clsr_pkg::MOD_ONE)))
      else $error("multiplier result not reduced");

   a_table_entry_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX) |-> (rd_data_ff != '0 && rd_data_ff < clsr_pkg::MOD_ONE))
      else $error("shuffle table entry out of range");

   a_sample_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX) |=> (last_ff != '0))
      else $error("sample wrapped to zero");
`endif

endmodule

>>> sim/clsr_checker.sv
// ----------------------------------------------------------------------------
// clsr_checker
// Watches both streams of the combined LCG / shuffle-table generator. It
// keeps its own copy of the two streams, the last sample and the shuffle
// table, predicts one sample word per accepted next word, and compares
// every result word with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clsr_checker #(
   parameter int TABLE_SIZE   = clsr_pkg::DEFAULT_TABLE_SIZE,
   parameter int WARMUP_EXTRA = clsr_pkg::DEFAULT_WARMUP_EXTRA
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] seed
   input  logic [0:0]  req_tuser,   // [0] op
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // [30:0] sample, [62:31] fraction, [63] zero
   output int          mismatches,
   output int          pending
);

   localparam longint MOD_A    = clsr_pkg::MOD_ONE;
   localparam longint MOD_B    = clsr_pkg::MOD_TWO;
   localparam longint MUL_A    = clsr_pkg::MUL_ONE;
   localparam longint MUL_B    = clsr_pkg::MUL_TWO;
   localparam longint SEED_B   = clsr_pkg::SECOND_SEED;
   localparam longint FRAC_TOP = clsr_pkg::FRAC_MAX;
   localparam longint SLOT_DIV = 1 + (MOD_A - 2) / TABLE_SIZE;

   typedef struct packed {
      logic [30:0] sample;
      logic [31:0] fraction;
   } draw_word_type;

   longint        strm_a;
   longint        strm_b;
   longint        prev_sample;
   longint        shuffle [TABLE_SIZE];
   draw_word_type expected_draws [$];
   int            fail_count;

   // direct (x * mul) mod m, exact in 64 bits for x below 2^31
   function automatic longint mulmod(longint x, longint mul, longint modulus);
      return (x * mul) % modulus;
   endfunction

   task automatic load_streams(input longint seed_val);
      strm_a = (seed_val < 1) ? 1 : seed_val;
      strm_b = SEED_B;
      for (int j = TABLE_SIZE + WARMUP_EXTRA - 1; j >= 0; j--) begin
         strm_a = mulmod(strm_a, MUL_A, MOD_A);
         if (j < TABLE_SIZE)
            shuffle[j] = strm_a;
      end
      prev_sample = shuffle[0];
   endtask

   task automatic predict_word(input logic op, input logic [31:0] seed_bits);
      longint        seed_val;
      longint        slot;
      longint        frac;
      draw_word_type want;
      if (op == clsr_pkg::OP_RESEED) begin
         seed_val = $signed(seed_bits);
         load_streams(seed_val);
      end else begin
         // never seeded, or stream one collapsed to zero
         if (prev_sample <= 0)
            load_streams(1);
         strm_a = mulmod(strm_a, MUL_A, MOD_A);
         strm_b = mulmod(strm_b, MUL_B, MOD_B);
         slot = prev_sample / SLOT_DIV;
         if (slot < 0)
            slot = 0;
         if (slot >= TABLE_SIZE)
            slot = TABLE_SIZE - 1;
         prev_sample = shuffle[slot] - strm_b;
         shuffle[slot] = strm_a;
         if (prev_sample < 1)
            prev_sample += MOD_A - 1;
         frac = (prev_sample <<< 32) / MOD_A;
         if (frac > FRAC_TOP)
            frac = FRAC_TOP;
         want.sample   = prev_sample[30:0];
         want.fraction = frac[31:0];
         expected_draws.push_back(want);
      end
   endtask

   always @(posedge clock) begin : watch
      draw_word_type got;
      draw_word_type want;
      if (reset) begin
         strm_a = 1;
         strm_b = SEED_B;
         prev_sample = 0;
         foreach (shuffle[i])
            shuffle[i] = 0;
         expected_draws.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.sample   = rsp_tdata[30:0];
            got.fraction = rsp_tdata[62:31];
            if (expected_draws.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result word %h with nothing predicted", $realtime, rsp_tdata);
            end else begin
               want = expected_draws.pop_front();
               if (got.sample !== want.sample || got.fraction !== want.fraction) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: sample exp %0d got %0d, fraction exp %0d got %0d",
                              $realtime, want.sample, got.sample,
                              want.fraction, got.fraction);
               end
            end
         end
         if (req_tvalid && req_tready)
            predict_word(req_tuser[0], req_tdata);
      end
      pending    <= expected_draws.size();
      mismatches <= fail_count;
   end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the combined LCG / shuffle-table generator with directed reseeds
// and draws, then random reseed-and-draw runs under bursty input and a
// stalling output side. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int WORD_TOTAL = 950;
   localparam int HOLD_LEN   = 600;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;     // [31:0] seed
   logic [0:0]  req_tuser  = '0;     // [0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;           // [30:0] sample, [62:31] fraction, [63] zero

   int mismatches;
   int pending;
   int words_sent = 0;
   int burst_left = 0;
   int hold_asks  = 0;

   // receiver-side pattern state
   int hold_seen  = 0;
   int stall_left = 0;
   int pat_mode   = 0;
   int pat_left   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   combined_lcg_shuffle_rng i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   clsr_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // output side: random stretches of always-ready, coin-flip and mostly-stalled
   always @(posedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen  = hold_asks;
         stall_left = HOLD_LEN;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (pat_left == 0) begin
            pat_mode = $urandom_range(0, 2);
            pat_left = $urandom_range(5, 60);
         end else begin
            pat_left--;
         end
         case (pat_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) == 1);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic send_word(input logic op, input logic [31:0] seed);
      int gap_len;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= seed;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap_len > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap_len) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   function automatic logic [31:0] pick_seed();
      case ($urandom_range(0, 19))
         0, 1, 2: return $urandom_range(0, 100);
         3, 4:    return 32'h8000_0000 | $urandom();
         5:       return 32'(clsr_pkg::MOD_ONE);
         6, 7:    return $urandom_range(32'h7FFF_FFFF, 32'h7FFF_FF00);
         default: return $urandom();
      endcase
   endfunction

   initial begin : stimulus
      int  run_kind;
      int  run_len;
      bit  held;
      bit  drained;
      held    = 1'b0;
      drained = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // draw before any reseed seeds with one on its own
      send_word(clsr_pkg::OP_NEXT, $urandom());
      send_word(clsr_pkg::OP_NEXT, $urandom());
      // seeds below one load one
      send_word(clsr_pkg::OP_RESEED, 32'h0000_0000);
      send_word(clsr_pkg::OP_NEXT, $urandom());
      send_word(clsr_pkg::OP_RESEED, 32'hFFFF_FFFF);
      send_word(clsr_pkg::OP_NEXT, $urandom());
      send_word(clsr_pkg::OP_RESEED, 32'h8000_0000);
      send_word(clsr_pkg::OP_NEXT, $urandom());
      send_word(clsr_pkg::OP_RESEED, 32'h7FFF_FFFF);
      send_word(clsr_pkg::OP_NEXT, $urandom());
      // seed equal to the modulus: stream one collapses, next draw reseeds
      send_word(clsr_pkg::OP_RESEED, 32'(clsr_pkg::MOD_ONE));
      send_word(clsr_pkg::OP_NEXT, $urandom());
      send_word(clsr_pkg::OP_NEXT, $urandom());
      send_word(clsr_pkg::OP_RESEED, 32'(clsr_pkg::MOD_ONE) - 32'd1);
      send_word(clsr_pkg::OP_NEXT, $urandom());
      send_word(clsr_pkg::OP_RESEED, 32'h0000_0001);
      send_word(clsr_pkg::OP_NEXT, 32'hFFFF_FFFF);
      send_word(clsr_pkg::OP_NEXT, 32'h0000_0000);
      send_word(clsr_pkg::OP_RESEED, 32'h5555_5555);
      send_word(clsr_pkg::OP_RESEED, 32'hAAAA_AAAA);
      send_word(clsr_pkg::OP_NEXT, $urandom());
      wait_drained();

      // mostly reseed followed by a run of draws, some stray words
      while (words_sent < WORD_TOTAL) begin
         if (!held && words_sent >= 350) begin
            hold_asks++;
            held = 1'b1;
         end
         if (!drained && words_sent >= 650) begin
            wait_drained();
            drained = 1'b1;
         end
         run_kind = $urandom_range(0, 9);
         if (run_kind == 0) begin
            send_word(clsr_pkg::OP_NEXT, $urandom());
         end else if (run_kind == 1) begin
            send_word(clsr_pkg::OP_RESEED, pick_seed());
         end else begin
            send_word(clsr_pkg::OP_RESEED, pick_seed());
            run_len = $urandom_range(1, 30);
            repeat (run_len) send_word(clsr_pkg::OP_NEXT, $urandom());
         end
      end

      wait_drained();
      // a trailing reseed may still be running
      repeat (200) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> combined_lcg_shuffle_rng.f
hdl/clsr_pkg.sv
hdl/clsr_modmul.sv
hdl/combined_lcg_shuffle_rng.sv
sim/clsr_checker.sv
sim/tb_top.sv
